// ===== hw/rtl/mpr_pkg.sv =====
package mpr_pkg;

  // Default sizes
  localparam int MAX_COLS_DEF   = 1024;
  localparam int MAX_ROWS_DEF   = 1024;
  localparam int MAX_REP_DEF    = 16;
  localparam int DATA_WIDTH_DEF = 64;

  // Fixed port widths
  localparam int ELEM_W     = 64;
  localparam int POS_W      = 14;
  localparam int DIM_W      = 11;
  localparam int REP_W      = 5;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 11;

  // Descriptor queue depth between front and back
  localparam int Q_DEPTH = 4;

  // Item opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_REPLAY = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_FACTOR = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ORDER      = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REP_ROWS     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REP_COLS     = 8'd3;

  // Per-item job handed from front to back (value travels beside it)
  typedef struct packed {
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col_base;
    logic [REP_W-1:0]    copies;
    logic [STATUS_W-1:0] status;
  } job_ctl_t;

endpackage

// ===== hw/rtl/matrix_pixel_replication.sv =====
// An accepted item passes stage 1, the descriptor queue and the output beat register before
// its first beat shows on the result ports. The single output beat stage emits one result
// beat per cycle while the receiver pops; an item yields rep_cols beats (one for an error).
// Input takes one item per cycle until the descriptor queue and stage 1 are full.
// Reset (rst_n low at a clock edge): registers go to 1, position and all queues empty;
// line buffer contents are left as they are and are never read before being written.
module matrix_pixel_replication #(
  parameter int MAX_COLS   = mpr_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = mpr_pkg::MAX_ROWS_DEF,
  parameter int MAX_REP    = mpr_pkg::MAX_REP_DEF,
  parameter int DATA_WIDTH = mpr_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpr_pkg::CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_op,
  input  logic [mpr_pkg::ELEM_W-1:0]     in_elem_value,
  // result beats
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [mpr_pkg::ELEM_W-1:0]     out_value,
  output logic [mpr_pkg::POS_W-1:0]      out_row,
  output logic [mpr_pkg::POS_W-1:0]      out_col,
  output logic                           out_last,
  output logic [mpr_pkg::STATUS_W-1:0]   out_status
);

  localparam int CTL_W = $bits(mpr_pkg::job_ctl_t);
  localparam int JOB_W = DATA_WIDTH + CTL_W;

  // Front: checks the item, tracks the row/pass position, owns the line buffer.
  logic                  f_push;
  logic [DATA_WIDTH-1:0] f_value;
  mpr_pkg::job_ctl_t     f_ctl;

  // Queue head, seen by the back end
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  logic [JOB_W-1:0]      q_head;
  logic [DATA_WIDTH-1:0] q_value;
  mpr_pkg::job_ctl_t     q_ctl;

  mpr_front #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .MAX_REP    (MAX_REP),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_op         (in_op),
    .in_elem_value (in_elem_value),
    .q_push        (f_push),
    .q_full        (q_full),
    .q_value       (f_value),
    .q_ctl         (f_ctl)
  );

  // Short job queue decouples checking from the copy sweep
  mpr_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (mpr_pkg::Q_DEPTH)
  ) u_job_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data ({f_value, f_ctl}),
    .full      (q_full),
    .pop       (q_pop),
    .head_data (q_head),
    .empty     (q_empty)
  );

  assign q_value = q_head[JOB_W-1:CTL_W];
  assign q_ctl   = q_head[CTL_W-1:0];

  // Back: emits one copy per beat into the result register
  mpr_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_value    (q_value),
    .q_ctl      (q_ctl),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_value  (out_value),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_last   (out_last),
    .out_status (out_status)
  );

endmodule

// ===== hw/rtl/mpr_ram.sv =====
module mpr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/mpr_fifo.sv =====
module mpr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & ~empty;
  assign head_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/mpr_front.sv =====
module mpr_front #(
  parameter int MAX_COLS   = mpr_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = mpr_pkg::MAX_ROWS_DEF,
  parameter int MAX_REP    = mpr_pkg::MAX_REP_DEF,
  parameter int DATA_WIDTH = mpr_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mpr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mpr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_op,
  input  logic [mpr_pkg::ELEM_W-1:0]        in_elem_value,
  output logic                              q_push,
  input  logic                              q_full,
  output logic [DATA_WIDTH-1:0]             q_value,
  output mpr_pkg::job_ctl_t                 q_ctl
);

  localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W  = 14;
  localparam int ROW_PW = ROW_W + mpr_pkg::REP_W + 1;
  localparam int COL_PW = COL_AW + mpr_pkg::REP_W;
  localparam int PASS_W = mpr_pkg::REP_W + 1;

  // Configuration
  logic [mpr_pkg::DIM_W-1:0] row_count_r;
  logic [mpr_pkg::DIM_W-1:0] column_count_r;
  logic [mpr_pkg::REP_W-1:0] rep_rows_r;
  logic [mpr_pkg::REP_W-1:0] rep_cols_r;

  // Position
  logic [ROW_W-1:0]          in_row_r;
  logic [COL_AW-1:0]         in_col_r;
  logic [mpr_pkg::REP_W-1:0] replay_pass_r;
  logic [COL_AW-1:0]         replay_col_r;
  logic                      replaying_r;

  // Stage 1: waits for line buffer read data
  logic                      s1_valid_r;
  logic                      s1_from_ram_r;
  logic [DATA_WIDTH-1:0]     s1_value_r;
  mpr_pkg::job_ctl_t         s1_ctl_r;

  logic                          cfg_wr;
  logic                          accept;
  logic                          is_load;
  logic                          bad_factor;
  logic                          bad_size;
  logic                          bad_order;
  logic [mpr_pkg::STATUS_W-1:0]  status;
  logic                          ok_load;
  logic                          ok_replay;
  logic [COL_AW-1:0]             idx;
  logic [COL_PW-1:0]             col_prod;
  logic [ROW_PW-1:0]             row_sum;
  logic                          row_wrap;
  logic [ROW_W-1:0]              row_inc;
  logic                          load_col_end;
  logic                          replay_col_end;
  logic                          pass_end;
  logic [DATA_WIDTH-1:0]         load_value;
  logic [DATA_WIDTH-1:0]         ram_rdata;
  mpr_pkg::job_ctl_t             ctl;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign in_full   = s1_valid_r & q_full;
  assign accept    = in_push & ~in_full;
  assign is_load   = (in_op == mpr_pkg::OP_LOAD);

  assign bad_factor = (rep_rows_r == '0) || (rep_cols_r == '0) ||
                      (32'(rep_rows_r) > 32'(MAX_REP)) || (32'(rep_cols_r) > 32'(MAX_REP));
  assign bad_size   = (row_count_r == '0) || (column_count_r == '0) ||
                      (32'(row_count_r) > 32'(MAX_ROWS)) ||
                      (32'(column_count_r) > 32'(MAX_COLS));
  assign bad_order  = (is_load && replaying_r) || (!is_load && !replaying_r);

  always_comb begin
    if (bad_factor) begin
      status = mpr_pkg::ST_BAD_FACTOR;
    end else if (bad_size) begin
      status = mpr_pkg::ST_EMPTY;
    end else if (bad_order) begin
      status = mpr_pkg::ST_ORDER;
    end else begin
      status = mpr_pkg::ST_OK;
    end
  end

  assign ok_load   = accept && (status == mpr_pkg::ST_OK) && is_load;
  assign ok_replay = accept && (status == mpr_pkg::ST_OK) && !is_load;

  // Expanded-matrix coordinates of the first copy
  assign idx      = is_load ? in_col_r : replay_col_r;
  assign col_prod = COL_PW'(idx) * COL_PW'(rep_cols_r);
  assign row_sum  = ROW_PW'(in_row_r) * ROW_PW'(rep_rows_r) +
                    (is_load ? '0 : ROW_PW'(replay_pass_r));

  always_comb begin
    if (status == mpr_pkg::ST_OK) begin
      ctl.row      = mpr_pkg::POS_W'(row_sum);
      ctl.col_base = mpr_pkg::POS_W'(col_prod);
      ctl.copies   = rep_cols_r;
    end else begin
      ctl.row      = '0;
      ctl.col_base = '0;
      ctl.copies   = mpr_pkg::REP_W'(1);
    end
    ctl.status = status;
  end

  assign row_wrap       = (CNT_W'(in_row_r) + 1'b1) >= CNT_W'(row_count_r);
  assign row_inc        = row_wrap ? '0 : in_row_r + 1'b1;
  assign load_col_end   = (CNT_W'(in_col_r) + 1'b1) >= CNT_W'(column_count_r);
  assign replay_col_end = (CNT_W'(replay_col_r) + 1'b1) >= CNT_W'(column_count_r);
  assign pass_end       = (PASS_W'(replay_pass_r) + 1'b1) >= PASS_W'(rep_rows_r);
  assign load_value     = in_elem_value[DATA_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= mpr_pkg::DIM_W'(1);
      column_count_r <= mpr_pkg::DIM_W'(1);
      rep_rows_r     <= mpr_pkg::REP_W'(1);
      rep_cols_r     <= mpr_pkg::REP_W'(1);
      in_row_r       <= '0;
      in_col_r       <= '0;
      replay_pass_r  <= '0;
      replay_col_r   <= '0;
      replaying_r    <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index)
        mpr_pkg::REG_ROW_COUNT: begin
          row_count_r <= cfg_data[mpr_pkg::DIM_W-1:0];
        end
        mpr_pkg::REG_COLUMN_COUNT: begin
          column_count_r <= cfg_data[mpr_pkg::DIM_W-1:0];
        end
        mpr_pkg::REG_REP_ROWS: begin
          rep_rows_r <= cfg_data[mpr_pkg::REP_W-1:0];
        end
        mpr_pkg::REG_REP_COLS: begin
          rep_cols_r <= cfg_data[mpr_pkg::REP_W-1:0];
        end
        default: begin
        end
      endcase
      // any known register restarts the matrix
      if (cfg_index <= mpr_pkg::REG_REP_COLS) begin
        in_row_r      <= '0;
        in_col_r      <= '0;
        replay_pass_r <= '0;
        replay_col_r  <= '0;
        replaying_r   <= 1'b0;
      end
    end else if (ok_load) begin
      if (load_col_end) begin
        in_col_r <= '0;
        if (rep_rows_r > mpr_pkg::REP_W'(1)) begin
          replaying_r   <= 1'b1;
          replay_pass_r <= mpr_pkg::REP_W'(1);
          replay_col_r  <= '0;
        end else begin
          in_row_r <= row_inc;
        end
      end else begin
        in_col_r <= in_col_r + 1'b1;
      end
    end else if (ok_replay) begin
      if (replay_col_end) begin
        replay_col_r <= '0;
        if (pass_end) begin
          replay_pass_r <= '0;
          replaying_r   <= 1'b0;
          in_row_r      <= row_inc;
        end else begin
          replay_pass_r <= replay_pass_r + 1'b1;
        end
      end else begin
        replay_col_r <= replay_col_r + 1'b1;
      end
    end
  end

  mpr_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_COLS)
  ) u_line_buf (
    .clk   (clk),
    .we    (ok_load),
    .waddr (in_col_r),
    .wdata (load_value),
    .re    (ok_replay),
    .raddr (replay_col_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept | (s1_valid_r & q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_from_ram_r <= ok_replay;
      s1_value_r    <= ok_load ? load_value : '0;
      s1_ctl_r      <= ctl;
    end
  end

  // read data stays put while stage 1 stalls: no read is issued then
  assign q_push  = s1_valid_r & ~q_full;
  assign q_value = s1_from_ram_r ? ram_rdata : s1_value_r;
  assign q_ctl   = s1_ctl_r;

endmodule

// ===== hw/rtl/mpr_back.sv =====
module mpr_back #(
  parameter int DATA_WIDTH = mpr_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  logic [DATA_WIDTH-1:0]             q_value,
  input  mpr_pkg::job_ctl_t                 q_ctl,
  output logic                              q_pop,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [mpr_pkg::ELEM_W-1:0]        out_value,
  output logic [mpr_pkg::POS_W-1:0]         out_row,
  output logic [mpr_pkg::POS_W-1:0]         out_col,
  output logic                              out_last,
  output logic [mpr_pkg::STATUS_W-1:0]      out_status
);

  logic [mpr_pkg::REP_W-1:0]    copy_r;
  logic                         out_valid_r;
  logic [DATA_WIDTH-1:0]        value_r;
  logic [mpr_pkg::POS_W-1:0]    row_r;
  logic [mpr_pkg::POS_W-1:0]    col_r;
  logic                         last_r;
  logic [mpr_pkg::STATUS_W-1:0] status_r;
  logic                         beat_taken;
  logic                         load_beat;
  logic                         is_last;

  assign beat_taken = out_pop & out_valid_r;
  assign load_beat  = ~q_empty & (~out_valid_r | beat_taken);
  assign is_last    = ((copy_r + 1'b1) == q_ctl.copies);
  assign q_pop      = load_beat & is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      copy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= load_beat | (out_valid_r & ~beat_taken);
      if (load_beat) begin
        copy_r <= is_last ? '0 : copy_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_beat) begin
      value_r  <= q_value;
      row_r    <= q_ctl.row;
      col_r    <= q_ctl.col_base + mpr_pkg::POS_W'(copy_r);
      last_r   <= is_last;
      status_r <= q_ctl.status;
    end
  end

  assign out_empty  = ~out_valid_r;
  assign out_value  = mpr_pkg::ELEM_W'(value_r);
  assign out_row    = row_r;
  assign out_col    = col_r;
  assign out_last   = last_r;
  assign out_status = status_r;

endmodule

// ===== tb/matrix_pixel_replication_tb.sv =====
module matrix_pixel_replication_tb;
  import mpr_pkg::*;

  // Run shape
  localparam int SETTLE_CYCLES  = 8;     // lets the pipe go quiet after the last owed beat
  localparam int RX_HOLD_CYCLES = 300;   // long receiver stall, fills the block
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake on any channel
  localparam int RANDOM_ITEMS   = 280;
  localparam int MAX_REPORTS    = 100;

  // Register indexes that decode to nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW = REG_REP_COLS + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = '1;

  // One result beat as it leaves the block
  typedef struct packed {
    logic [ELEM_W-1:0]   value;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col;
    logic                last;
    logic [STATUS_W-1:0] status;
  } beat_t;

  // One row of the directed table: a register write or an item
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  op;
    logic [ELEM_W-1:0]     word;
    bit                    fixed;   // expected beat typed into the table
    beat_t                 want;
  } step_t;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  cfg_valid     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  in_push       = 1'b0;
  logic                  in_op         = OP_LOAD;
  logic [ELEM_W-1:0]     in_elem_value = '0;
  logic                  out_pop       = 1'b0;
  logic                  cfg_ready;
  logic                  in_full;
  logic                  out_empty;
  logic [ELEM_W-1:0]     out_value;
  logic [POS_W-1:0]      out_row;
  logic [POS_W-1:0]      out_col;
  logic                  out_last;
  logic [STATUS_W-1:0]   out_status;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  matrix_pixel_replication dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_op         (in_op),
    .in_elem_value (in_elem_value),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_value     (out_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_last      (out_last),
    .out_status    (out_status)
  );

  // ---------------------------------------------------------------------------
  // Upscaler shadow: registers, line buffer and sweep position
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]  shd_rows, shd_cols;
  logic [REP_W-1:0]  shd_rep_r, shd_rep_c;
  logic [ELEM_W-1:0] shd_line [MAX_COLS_DEF];
  int unsigned       shd_in_row, shd_in_col, shd_pass, shd_sweep_col;
  bit                shd_replaying;

  beat_t due_beats[$];   // expanded copies still owed by the block, oldest first
  step_t plan[$];        // directed table

  // Bookkeeping
  int  errors        = 0;
  int  items_sent    = 0;
  int  cfg_writes    = 0;
  int  beats_checked = 0;
  int  status_seen [4];
  int  idle_cycles   = 0;
  bit  tx_gaps_on    = 1'b1;
  bit  rx_hold_go    = 1'b0;
  beat_t oldest;

  function automatic void restart_matrix();
    shd_in_row    = 0;
    shd_in_col    = 0;
    shd_pass      = 0;
    shd_sweep_col = 0;
    shd_replaying = 1'b0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0]  idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_ROW_COUNT:    shd_rows  = val;
      REG_COLUMN_COUNT: shd_cols  = val;
      REG_REP_ROWS:     shd_rep_r = val[REP_W-1:0];
      REG_REP_COLS:     shd_rep_c = val[REP_W-1:0];
      default:          return;   // undecoded index: no effect, position kept
    endcase
    restart_matrix();   // any real write restarts the matrix
  endfunction

  // Works out the beats one item causes and advances the sweep position.
  function automatic void expand_item(input logic op, input logic [ELEM_W-1:0] word,
                                      ref beat_t beats[$]);
    logic [STATUS_W-1:0] code;
    logic [ELEM_W-1:0]   src;
    int unsigned         slot, exp_row, col_pos;
    int                  k;
    bit                  row_done;
    code     = ST_OK;
    row_done = 1'b0;
    // checks in priority order: factors, matrix size, then op sequencing
    if (shd_rep_r == 0 || shd_rep_c == 0 || shd_rep_r > MAX_REP_DEF ||
        shd_rep_c > MAX_REP_DEF)
      code = ST_BAD_FACTOR;
    else if (shd_rows == 0 || shd_cols == 0 || shd_rows > MAX_ROWS_DEF ||
             shd_cols > MAX_COLS_DEF)
      code = ST_EMPTY;
    else if ((op == OP_LOAD && shd_replaying) || (op == OP_REPLAY && !shd_replaying))
      code = ST_ORDER;
    if (code != ST_OK) begin
      beats.insert(beats.size(), beat_t'{value: '0, row: '0, col: '0, last: 1'b1,
                                         status: code});
      return;
    end
    if (op == OP_LOAD) begin
      slot           = shd_in_col;
      src            = word;
      shd_line[slot] = word;
      exp_row        = shd_in_row * shd_rep_r;
      shd_in_col++;
      if (shd_in_col >= shd_cols) begin
        shd_in_col = 0;
        if (shd_rep_r > 1) begin
          shd_replaying = 1'b1;
          shd_pass      = 1;
          shd_sweep_col = 0;
        end else begin
          row_done = 1'b1;
        end
      end
    end else begin
      slot    = shd_sweep_col;
      src     = shd_line[slot];
      exp_row = shd_in_row * shd_rep_r + shd_pass;
      shd_sweep_col++;
      if (shd_sweep_col >= shd_cols) begin
        shd_sweep_col = 0;
        shd_pass++;
        if (shd_pass >= shd_rep_r) begin
          shd_pass      = 0;
          shd_replaying = 1'b0;
          row_done      = 1'b1;
        end
      end
    end
    // input row done: next row, wrapping to a fresh matrix after the last
    if (row_done)
      shd_in_row = (shd_in_row + 1 >= shd_rows) ? 0 : shd_in_row + 1;
    for (k = 0; k < shd_rep_c; k++) begin
      col_pos = slot * shd_rep_c + k;
      beats.insert(beats.size(), beat_t'{value: src, row: exp_row[POS_W-1:0],
                                         col: col_pos[POS_W-1:0],
                                         last: (k == shd_rep_c - 1), status: ST_OK});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows
  // ---------------------------------------------------------------------------
  function automatic step_t mk_cfg(input logic [CFG_IDX_W-1:0]  idx,
                                   input logic [CFG_DATA_W-1:0] val);
    step_t s;
    s         = '{default: '0};
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic step_t mk_item(input logic op, input logic [ELEM_W-1:0] word);
    step_t s;
    s      = '{default: '0};
    s.op   = op;
    s.word = word;
    return s;
  endfunction

  // single beat at the origin, known up front
  function automatic step_t mk_fixed(input logic op, input logic [ELEM_W-1:0] word,
                                     input logic [ELEM_W-1:0] want_value,
                                     input logic [STATUS_W-1:0] code);
    step_t s;
    s       = mk_item(op, word);
    s.fixed = 1'b1;
    s.want  = '{value: want_value, row: '0, col: '0, last: 1'b1, status: code};
    return s;
  endfunction

  function automatic void add_step(input step_t s);
    plan.insert(plan.size(), s);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Entered just after an edge; offers one item and waits for its accept.
  task automatic send_item(input logic op, input logic [ELEM_W-1:0] word,
                           input bit fixed, input beat_t want);
    beat_t fresh[$];
    int    gap;
    int    pick;
    gap = 0;
    if (tx_gaps_on) begin
      pick = $urandom_range(0, 99);
      if (pick >= 93)
        gap = $urandom_range(10, 40);
      else if (pick >= 55)
        gap = $urandom_range(1, 3);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_push       <= 1'b0;
      in_op         <= 1'($urandom_range(0, 1));      // junk while idle
      in_elem_value <= {$urandom, $urandom};
      repeat (gap) @(negedge clk);
    end
    in_push       <= 1'b1;
    in_op         <= op;
    in_elem_value <= word;
    do @(posedge clk); while (in_full !== 1'b0);
    expand_item(op, word, fresh);
    if (fixed)
      due_beats.insert(due_beats.size(), want);
    else
      foreach (fresh[i]) due_beats.insert(due_beats.size(), fresh[i]);
    items_sent++;
  endtask

  // Drop push, wait for every owed beat, then let the pipe go quiet.
  task automatic drain_and_settle();
    @(negedge clk);
    in_push <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_reg(idx, val);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: short gaps mostly, a few long ones, busy stretches, and one
  // long hold on request
  // ---------------------------------------------------------------------------
  initial begin : rx_proc
    int gap_left;
    int run_left;
    int held;
    int r;
    gap_left = 0;
    run_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (rx_hold_go) begin
        rx_hold_go = 1'b0;
        out_pop   <= 1'b0;
        for (held = 0; held < RX_HOLD_CYCLES; held++) @(negedge clk);
      end
      if (run_left > 0) begin
        out_pop <= 1'b1;
        run_left--;
      end else if (gap_left > 0) begin
        out_pop <= 1'b0;
        gap_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8)
          run_left = $urandom_range(20, 80);
        else if (r < 30)
          gap_left = $urandom_range(1, 3);
        else if (r < 33)
          gap_left = $urandom_range(15, 60);
        out_pop <= (gap_left == 0);
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  function automatic void report(input string msg);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s", $time, msg);
    else if (errors == MAX_REPORTS + 1)
      $display("%0t: further mismatches not shown", $time);
  endfunction

  function automatic void check_field(input string what, input logic [ELEM_W-1:0] want,
                                      input logic [ELEM_W-1:0] got);
    if (want !== got)
      report($sformatf("%s mismatch: expected %0h, got %0h", what, want, got));
  endfunction

  // Every popped beat is matched against the oldest owed copy.
  always @(posedge clk) begin
    if (rst_n && out_pop === 1'b1 && out_empty === 1'b0) begin
      if (due_beats.size() == 0) begin
        report($sformatf("unexpected beat: expected none, got value %0h row %0d col %0d %s",
                         out_value, out_row, out_col,
                         $sformatf("last %0b status %0d", out_last, out_status)));
      end else begin
        oldest = due_beats.pop_front();
        beats_checked++;
        status_seen[oldest.status]++;
        check_field("out_value", oldest.value, out_value);
        check_field("out_row", ELEM_W'(oldest.row), ELEM_W'(out_row));
        check_field("out_col", ELEM_W'(oldest.col), ELEM_W'(out_col));
        check_field("out_last", ELEM_W'(oldest.last), ELEM_W'(out_last));
        check_field("out_status", ELEM_W'(oldest.status), ELEM_W'(out_status));
      end
    end
  end

  // Watchdog: no handshake on any channel for too long ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d beats still owed",
               $time, idle_cycles, due_beats.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int                phase;
    int                n;
    int                directed_items;
    logic              opv;
    logic [ELEM_W-1:0] wordv;
    logic [DIM_W-1:0]  rows_v, cols_v;
    logic [REP_W-1:0]  rr_v, rc_v;
    logic [5:0]        junk;

    // shadow comes out of reset like the block: all registers 1
    shd_rows  = 1;
    shd_cols  = 1;
    shd_rep_r = 1;
    shd_rep_c = 1;
    restart_matrix();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- after reset: 1x1 matrix, 1x1 factors, each load is one beat at origin
    add_step(mk_fixed(OP_LOAD, '0, '0, ST_OK));
    add_step(mk_fixed(OP_LOAD, '1, '1, ST_OK));
    add_step(mk_fixed(OP_REPLAY, {$urandom, $urandom}, '0, ST_ORDER));
    // --- illegal factors: zero and above the max, both directions
    add_step(mk_cfg(REG_REP_ROWS, 11'd0));
    add_step(mk_fixed(OP_LOAD, {$urandom, $urandom}, '0, ST_BAD_FACTOR));
    add_step(mk_cfg(REG_REP_ROWS, 11'd17));
    add_step(mk_fixed(OP_REPLAY, {$urandom, $urandom}, '0, ST_BAD_FACTOR));
    add_step(mk_cfg(REG_REP_ROWS, 11'd16));
    add_step(mk_cfg(REG_REP_COLS, 11'd0));
    add_step(mk_fixed(OP_LOAD, {$urandom, $urandom}, '0, ST_BAD_FACTOR));
    add_step(mk_cfg(REG_REP_COLS, 11'd31));
    add_step(mk_fixed(OP_LOAD, {$urandom, $urandom}, '0, ST_BAD_FACTOR));
    // --- empty matrix; a bad factor outranks it
    add_step(mk_cfg(REG_REP_COLS, 11'd16));
    add_step(mk_cfg(REG_ROW_COUNT, 11'd0));
    add_step(mk_fixed(OP_LOAD, {$urandom, $urandom}, '0, ST_EMPTY));
    add_step(mk_cfg(REG_REP_COLS, 11'd0));
    add_step(mk_fixed(OP_LOAD, {$urandom, $urandom}, '0, ST_BAD_FACTOR));
    add_step(mk_cfg(REG_REP_COLS, 11'd16));
    add_step(mk_cfg(REG_ROW_COUNT, 11'd1025));
    add_step(mk_fixed(OP_LOAD, {$urandom, $urandom}, '0, ST_EMPTY));
    add_step(mk_cfg(REG_ROW_COUNT, 11'd1024));
    add_step(mk_cfg(REG_COLUMN_COUNT, 11'd0));
    add_step(mk_fixed(OP_LOAD, {$urandom, $urandom}, '0, ST_EMPTY));
    add_step(mk_cfg(REG_COLUMN_COUNT, 11'd2047));
    add_step(mk_fixed(OP_LOAD, {$urandom, $urandom}, '0, ST_EMPTY));
    // --- 2x2 matrix, 2x3 blocks: full sweep, sequencing errors, matrix wrap
    add_step(mk_cfg(REG_ROW_COUNT, 11'd2));
    add_step(mk_cfg(REG_COLUMN_COUNT, 11'd2));
    add_step(mk_cfg(REG_REP_ROWS, 11'd2));
    add_step(mk_cfg(REG_REP_COLS, 11'd3));
    add_step(mk_item(OP_LOAD, {$urandom, $urandom}));
    add_step(mk_fixed(OP_REPLAY, {$urandom, $urandom}, '0, ST_ORDER));
    add_step(mk_item(OP_LOAD, {$urandom, $urandom}));
    add_step(mk_cfg(REG_SPARE_LOW, '1));     // decodes to nothing, replay survives
    add_step(mk_fixed(OP_LOAD, {$urandom, $urandom}, '0, ST_ORDER));
    add_step(mk_item(OP_REPLAY, {$urandom, $urandom}));
    add_step(mk_item(OP_REPLAY, {$urandom, $urandom}));
    add_step(mk_item(OP_LOAD, {$urandom, $urandom}));
    add_step(mk_item(OP_LOAD, {$urandom, $urandom}));
    add_step(mk_item(OP_REPLAY, {$urandom, $urandom}));
    add_step(mk_item(OP_REPLAY, {$urandom, $urandom}));
    add_step(mk_item(OP_LOAD, {$urandom, $urandom}));   // wraps to row 0
    add_step(mk_cfg(REG_REP_COLS, 11'd3));              // restarts mid-row
    add_step(mk_item(OP_LOAD, {$urandom, $urandom}));
    // --- largest legal sizes: 16 beats per item
    add_step(mk_cfg(REG_ROW_COUNT, 11'd1024));
    add_step(mk_cfg(REG_COLUMN_COUNT, 11'd1024));
    add_step(mk_cfg(REG_REP_ROWS, 11'd16));
    add_step(mk_cfg(REG_REP_COLS, 11'd16));
    add_step(mk_item(OP_LOAD, '1));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_and_settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_item(plan[i].op, plan[i].word, plan[i].fixed, plan[i].want);
      end
    end
    drain_and_settle();
    directed_items = items_sent;

    // --- random phases: fresh setting, then mostly well-ordered sweeps
    phase = 0;
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      rows_v = ($urandom_range(0, 9) == 0) ? 11'd1024 : DIM_W'($urandom_range(1, 4));
      cols_v = ($urandom_range(0, 9) == 0) ? 11'd1024 : DIM_W'($urandom_range(1, 6));
      rr_v   = ($urandom_range(0, 4) == 0) ? 5'd16 : REP_W'($urandom_range(1, 4));
      rc_v   = ($urandom_range(0, 3) == 0) ? REP_W'($urandom_range(5, 16))
                                           : REP_W'($urandom_range(1, 4));
      // now and then an illegal setting so the error paths see traffic too
      if (phase > 1 && $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       rr_v   = $urandom_range(0, 1) ? 5'd0 : REP_W'($urandom_range(17, 31));
          1:       rc_v   = $urandom_range(0, 1) ? 5'd0 : REP_W'($urandom_range(17, 31));
          2:       rows_v = $urandom_range(0, 1) ? 11'd0 : DIM_W'($urandom_range(1025, 2047));
          default: cols_v = $urandom_range(0, 1) ? 11'd0 : DIM_W'($urandom_range(1025, 2047));
        endcase
      end
      write_reg(REG_ROW_COUNT, rows_v);
      write_reg(REG_COLUMN_COUNT, cols_v);
      junk = 6'($urandom);   // high data bits are dropped by the factor registers
      write_reg(REG_REP_ROWS, {junk, rr_v});
      junk = 6'($urandom);
      write_reg(REG_REP_COLS, {junk, rc_v});
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_SPARE_LOW), int'(REG_SPARE_TOP))),
                  CFG_DATA_W'($urandom));

      // second phase: back to back items against a long receiver hold
      tx_gaps_on = (phase != 1) && ($urandom_range(0, 3) != 0);
      if (phase == 1)
        rx_hold_go = 1'b1;

      n = $urandom_range(12, 40);
      repeat (n) begin
        // mostly the op the sweep wants next, some out of order
        if ($urandom_range(0, 99) < 88)
          opv = shd_replaying ? OP_REPLAY : OP_LOAD;
        else
          opv = shd_replaying ? OP_LOAD : OP_REPLAY;
        case ($urandom_range(0, 15))
          0:       wordv = '0;
          1:       wordv = '1;
          default: wordv = {$urandom, $urandom};
        endcase
        send_item(opv, wordv, 1'b0, '0);
        if ($urandom_range(0, 99) < 3)
          drain_and_settle();   // sender pauses until nothing is owed
      end
      drain_and_settle();
      phase++;
    end

    $display("Covered %0d items (%0d directed) over %0d settings, %0d register writes.",
             items_sent, directed_items, phase, cfg_writes);
    $display("Checked %0d beats: %0d ok, %0d bad factor, %0d empty, %0d out of order.",
             beats_checked, status_seen[ST_OK], status_seen[ST_BAD_FACTOR],
             status_seen[ST_EMPTY], status_seen[ST_ORDER]);
    if (errors == 0 && due_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
